@@ design/scd_pkg.sv @@
// Shared constants and types for the SCAN disk scheduler.
package scd_pkg;

  localparam int DEF_MAX_REQUESTS = 32;
  localparam int DEF_TRACK_BITS   = 10;
  localparam int DEF_MAX_TRACK    = 299;

  localparam int CFG_W     = 10;
  localparam int CFG_IDX_W = 2;
  localparam int MOVE_W    = 12;

  localparam logic [CFG_IDX_W-1:0] REG_MAX_TRACK  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_START_HEAD = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PREV_HEAD  = 2'd2;

  localparam logic RES_DONE    = 1'b0;
  localparam logic RES_SUMMARY = 1'b1;

  typedef struct packed {
    logic              eq;
    logic [MOVE_W-1:0] sum;
  } alu_res_t;

endpackage

@@ design/scd_ifs.sv @@
// Channel interfaces: request input, result output and register write port.
interface scd_req_if #(parameter int TRACK_BITS = scd_pkg::DEF_TRACK_BITS);
  logic                  valid;
  logic                  ready;
  logic [TRACK_BITS-1:0] request_track;
  logic                  last_request;
  modport source (output valid, request_track, last_request, input ready);
  modport sink   (input valid, request_track, last_request, output ready);
endinterface

interface scd_res_if #(parameter int TRACK_BITS = scd_pkg::DEF_TRACK_BITS);
  logic                      valid;
  logic                      ready;
  logic                      result_kind;
  logic [TRACK_BITS-1:0]     track_value;
  logic [scd_pkg::MOVE_W-1:0] travel_total;
  logic                      last_result;
  modport source (output valid, result_kind, track_value, travel_total, last_result,
                  input ready);
  modport sink   (input valid, result_kind, track_value, travel_total, last_result,
                  output ready);
endinterface

interface scd_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [scd_pkg::CFG_IDX_W-1:0] index;
  logic [scd_pkg::CFG_W-1:0]     data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

@@ design/scd_table.sv @@
// Request table: one write port, one registered read port.
module scd_table #(
  parameter int DEPTH      = scd_pkg::DEF_MAX_REQUESTS,
  parameter int TRACK_BITS = scd_pkg::DEF_TRACK_BITS
) (
  input  logic                                      clk,
  input  logic                                      wr_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [TRACK_BITS-1:0]                     wr_data,
  input  logic                                      rd_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [TRACK_BITS-1:0]                     rd_data
);
  logic [TRACK_BITS-1:0] mem [DEPTH];
  logic [TRACK_BITS-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;
endmodule

@@ design/scd_alu.sv @@
// Shared unit: track equality and accumulate of absolute track distance.
module scd_alu #(
  parameter int TRACK_BITS = scd_pkg::DEF_TRACK_BITS
) (
  input  logic [TRACK_BITS-1:0]      op_a,
  input  logic [TRACK_BITS-1:0]      op_b,
  input  logic [scd_pkg::MOVE_W-1:0] acc,
  output scd_pkg::alu_res_t          res
);
  import scd_pkg::*;

  logic [TRACK_BITS-1:0]        diff;
  logic [MOVE_W+TRACK_BITS-1:0] diff_ext;

  assign diff     = (op_a > op_b) ? (op_a - op_b) : (op_b - op_a);
  // movement is kept modulo 2^MOVE_W, so widen or drop high bits as needed
  assign diff_ext = {{MOVE_W{1'b0}}, diff};
  assign res.sum  = acc + diff_ext[MOVE_W-1:0];
  assign res.eq   = (op_a == op_b);
endmodule

@@ design/scd_seq.sv @@
// Sequencer: loads requests, steps the head and scans the table per step.
module scd_seq #(
  parameter int MAX_REQUESTS = scd_pkg::DEF_MAX_REQUESTS,
  parameter int TRACK_BITS   = scd_pkg::DEF_TRACK_BITS
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic [TRACK_BITS-1:0]     top_trk,
  input  logic [TRACK_BITS-1:0]     start_trk,
  input  logic [TRACK_BITS-1:0]     prev_trk,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [TRACK_BITS-1:0]     in_track,
  input  logic                      in_last,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic                      out_kind,
  output logic [TRACK_BITS-1:0]     out_track,
  output logic [scd_pkg::MOVE_W-1:0] out_move,
  output logic                      out_last,
  output logic                      tbl_wr_en,
  output logic [((MAX_REQUESTS > 1) ? $clog2(MAX_REQUESTS) : 1)-1:0] tbl_wr_addr,
  output logic [TRACK_BITS-1:0]     tbl_wr_data,
  output logic                      tbl_rd_en,
  output logic [((MAX_REQUESTS > 1) ? $clog2(MAX_REQUESTS) : 1)-1:0] tbl_rd_addr,
  input  logic [TRACK_BITS-1:0]     tbl_rd_data,
  output logic [TRACK_BITS-1:0]     alu_a,
  output logic [TRACK_BITS-1:0]     alu_b,
  output logic [scd_pkg::MOVE_W-1:0] alu_acc,
  input  scd_pkg::alu_res_t         alu_res
);
  import scd_pkg::*;

  localparam int IDX_W = (MAX_REQUESTS > 1) ? $clog2(MAX_REQUESTS) : 1;
  localparam int CNT_W = $clog2(MAX_REQUESTS + 1);
  localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_REQUESTS);

  localparam logic [2:0] S_LOAD    = 3'd0;
  localparam logic [2:0] S_SETUP   = 3'd1;
  localparam logic [2:0] S_MOVE    = 3'd2;
  localparam logic [2:0] S_READ    = 3'd3;
  localparam logic [2:0] S_CHECK   = 3'd4;
  localparam logic [2:0] S_SUMMARY = 3'd5;

  logic [2:0]              state_r, state_nxt;
  logic [CNT_W-1:0]        count_r, count_nxt;
  logic [CNT_W-1:0]        pending_r, pending_nxt;
  logic [IDX_W-1:0]        idx_r, idx_nxt;
  logic [TRACK_BITS-1:0]   head_r, head_nxt;
  logic [TRACK_BITS-1:0]   leg_r, leg_nxt;
  logic                    up_r, up_nxt;
  logic [MOVE_W-1:0]       sum_r, sum_nxt;
  logic [MAX_REQUESTS-1:0] served_r, served_nxt;
  logic                    out_valid_r, out_valid_nxt;
  logic                    out_kind_r, out_kind_nxt;
  logic [TRACK_BITS-1:0]   out_track_r, out_track_nxt;
  logic [MOVE_W-1:0]       out_move_r, out_move_nxt;
  logic                    out_last_r, out_last_nxt;

  logic                  out_free;
  logic                  in_acc;
  logic [TRACK_BITS-1:0] in_clamped;
  logic [TRACK_BITS-1:0] rd_clamped;
  logic [TRACK_BITS-1:0] start_clamped;
  logic                  hit;
  logic                  step_up;
  logic [CNT_W-1:0]      pend_after;
  logic                  last_idx;

  assign out_free      = !out_valid_r || out_ready;
  assign in_ready      = (state_r == S_LOAD);
  assign in_acc        = in_valid && in_ready;
  assign in_clamped    = (in_track > top_trk) ? top_trk : in_track;
  // entries are clamped again against the current top track when read
  assign rd_clamped    = (tbl_rd_data > top_trk) ? top_trk : tbl_rd_data;
  assign start_clamped = (start_trk > top_trk) ? top_trk : start_trk;

  assign alu_a   = (state_r == S_CHECK) ? rd_clamped : leg_r;
  assign alu_b   = head_r;
  assign alu_acc = sum_r;

  assign hit        = alu_res.eq && !served_r[idx_r];
  assign pend_after = pending_r - CNT_W'(hit);
  assign last_idx   = ((CNT_W'(idx_r) + CNT_W'(1)) == count_r);

  assign tbl_wr_en   = in_acc && (count_r < CNT_MAX);
  assign tbl_wr_addr = count_r[IDX_W-1:0];
  assign tbl_wr_data = in_clamped;
  assign tbl_rd_en   = (state_r == S_READ);
  assign tbl_rd_addr = idx_r;

  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    pending_nxt   = pending_r;
    idx_nxt       = idx_r;
    head_nxt      = head_r;
    leg_nxt       = leg_r;
    up_nxt        = up_r;
    sum_nxt       = sum_r;
    served_nxt    = served_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_kind_nxt  = out_kind_r;
    out_track_nxt = out_track_r;
    out_move_nxt  = out_move_r;
    out_last_nxt  = out_last_r;
    step_up       = up_r;

    unique case (state_r)
      S_LOAD: begin
        if (in_acc) begin
          if (count_r < CNT_MAX) begin
            count_nxt = count_r + CNT_W'(1);
          end
          if (in_last) begin
            state_nxt = S_SETUP;
          end
        end
      end
      S_SETUP: begin
        head_nxt    = start_clamped;
        leg_nxt     = start_clamped;
        up_nxt      = (prev_trk < start_clamped);
        sum_nxt     = '0;
        pending_nxt = count_r;
        state_nxt   = S_MOVE;
      end
      S_MOVE: begin
        // reverse at either end, closing the current leg
        if (head_r == top_trk) begin
          step_up = 1'b0;
          sum_nxt = alu_res.sum;
          leg_nxt = top_trk;
        end else if (head_r == '0) begin
          step_up = 1'b1;
          sum_nxt = alu_res.sum;
          leg_nxt = '0;
        end
        up_nxt    = step_up;
        head_nxt  = step_up ? (head_r + TRACK_BITS'(1)) : (head_r - TRACK_BITS'(1));
        idx_nxt   = '0;
        state_nxt = S_READ;
      end
      S_READ: begin
        state_nxt = S_CHECK;
      end
      S_CHECK: begin
        // hold on a hit until the output register is free
        if (!hit || out_free) begin
          if (hit) begin
            out_valid_nxt       = 1'b1;
            out_kind_nxt        = RES_DONE;
            out_track_nxt       = head_r;
            out_move_nxt        = '0;
            out_last_nxt        = 1'b0;
            served_nxt[idx_r]   = 1'b1;
            pending_nxt         = pend_after;
          end
          if (pend_after == '0) begin
            state_nxt = S_SUMMARY;
          end else if (last_idx) begin
            state_nxt = S_MOVE;
          end else begin
            idx_nxt   = idx_r + IDX_W'(1);
            state_nxt = S_READ;
          end
        end
      end
      S_SUMMARY: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_kind_nxt  = RES_SUMMARY;
          out_track_nxt = head_r;
          out_move_nxt  = alu_res.sum;
          out_last_nxt  = 1'b1;
          sum_nxt       = alu_res.sum;
          count_nxt     = '0;
          served_nxt    = '0;
          state_nxt     = S_LOAD;
        end
      end
      default: begin
        state_nxt = S_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_LOAD;
      count_r     <= '0;
      pending_r   <= '0;
      idx_r       <= '0;
      head_r      <= '0;
      leg_r       <= '0;
      up_r        <= 1'b0;
      sum_r       <= '0;
      served_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      pending_r   <= pending_nxt;
      idx_r       <= idx_nxt;
      head_r      <= head_nxt;
      leg_r       <= leg_nxt;
      up_r        <= up_nxt;
      sum_r       <= sum_nxt;
      served_r    <= served_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_kind_r  <= out_kind_nxt;
    out_track_r <= out_track_nxt;
    out_move_r  <= out_move_nxt;
    out_last_r  <= out_last_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_kind  = out_kind_r;
  assign out_track = out_track_r;
  assign out_move  = out_move_r;
  assign out_last  = out_last_r;
endmodule

@@ design/scan_disk_scheduler_unit.sv @@
// Top level of the SCAN disk scheduler: registers, table, shared unit, sequencer.
//
//  channel | dir | transaction carries
//  --------+-----+------------------------------------------------------
//  in_ch   | in  | request_track, last_request
//  out_ch  | out | result_kind, track_value, travel_total, last_result
//  cfg_ch  | in  | index (0 max_track, 1 start_head, 2 previous_head), data
//
//  Loading accepts one request per cycle; in_ch and cfg_ch are ready only while loading.
//  The sweep runs a setup state, then for each head move a move state plus a read
//  and a check state per stored request checked on that move (one read port on the
//  request table), ending early once the last request is served, then a summary state.
//  A stalled out_ch holds the sweep on the next completed request or the summary.
//  Reset clears control state; table contents stay undefined until written.
module scan_disk_scheduler_unit #(
  parameter int MAX_REQUESTS = scd_pkg::DEF_MAX_REQUESTS,
  parameter int TRACK_BITS   = scd_pkg::DEF_TRACK_BITS
) (
  input logic       clk,
  input logic       rst_n,
  scd_req_if.sink   in_ch,
  scd_res_if.source out_ch,
  scd_cfg_if.sink   cfg_ch
);
  import scd_pkg::*;

  localparam int IDX_W = (MAX_REQUESTS > 1) ? $clog2(MAX_REQUESTS) : 1;

  logic [CFG_W-1:0] max_track_r;
  logic [CFG_W-1:0] start_head_r;
  logic [CFG_W-1:0] prev_head_r;

  logic [TRACK_BITS+CFG_W-1:0] max_ext, start_ext, prev_ext;
  logic [TRACK_BITS-1:0]       max_trk, top_trk;

  logic                  tbl_wr_en, tbl_rd_en;
  logic [IDX_W-1:0]      tbl_wr_addr, tbl_rd_addr;
  logic [TRACK_BITS-1:0] tbl_wr_data, tbl_rd_data;
  logic [TRACK_BITS-1:0] alu_a, alu_b;
  logic [MOVE_W-1:0]     alu_acc;
  alu_res_t              alu_res;

  // hold register writes off while a sweep runs
  assign cfg_ch.ready = in_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_track_r  <= CFG_W'(DEF_MAX_TRACK);
      start_head_r <= '0;
      prev_head_r  <= '0;
    end else if (cfg_ch.valid && cfg_ch.ready) begin
      unique case (cfg_ch.index)
        REG_MAX_TRACK:  max_track_r  <= cfg_ch.data;
        REG_START_HEAD: start_head_r <= cfg_ch.data;
        REG_PREV_HEAD:  prev_head_r  <= cfg_ch.data;
        default: begin
          // unmapped index: drop the write
        end
      endcase
    end
  end

  // fit register values to the track width
  assign max_ext   = {{TRACK_BITS{1'b0}}, max_track_r};
  assign start_ext = {{TRACK_BITS{1'b0}}, start_head_r};
  assign prev_ext  = {{TRACK_BITS{1'b0}}, prev_head_r};
  assign max_trk   = max_ext[TRACK_BITS-1:0];
  assign top_trk   = (max_trk == '0) ? TRACK_BITS'(1) : max_trk;

  scd_table #(
    .DEPTH      (MAX_REQUESTS),
    .TRACK_BITS (TRACK_BITS)
  ) u_table (
    .clk     (clk),
    .wr_en   (tbl_wr_en),
    .wr_addr (tbl_wr_addr),
    .wr_data (tbl_wr_data),
    .rd_en   (tbl_rd_en),
    .rd_addr (tbl_rd_addr),
    .rd_data (tbl_rd_data)
  );

  scd_alu #(
    .TRACK_BITS (TRACK_BITS)
  ) u_alu (
    .op_a (alu_a),
    .op_b (alu_b),
    .acc  (alu_acc),
    .res  (alu_res)
  );

  scd_seq #(
    .MAX_REQUESTS (MAX_REQUESTS),
    .TRACK_BITS   (TRACK_BITS)
  ) u_seq (
    .clk         (clk),
    .rst_n       (rst_n),
    .top_trk     (top_trk),
    .start_trk   (start_ext[TRACK_BITS-1:0]),
    .prev_trk    (prev_ext[TRACK_BITS-1:0]),
    .in_valid    (in_ch.valid),
    .in_ready    (in_ch.ready),
    .in_track    (in_ch.request_track),
    .in_last     (in_ch.last_request),
    .out_valid   (out_ch.valid),
    .out_ready   (out_ch.ready),
    .out_kind    (out_ch.result_kind),
    .out_track   (out_ch.track_value),
    .out_move    (out_ch.travel_total),
    .out_last    (out_ch.last_result),
    .tbl_wr_en   (tbl_wr_en),
    .tbl_wr_addr (tbl_wr_addr),
    .tbl_wr_data (tbl_wr_data),
    .tbl_rd_en   (tbl_rd_en),
    .tbl_rd_addr (tbl_rd_addr),
    .tbl_rd_data (tbl_rd_data),
    .alu_a       (alu_a),
    .alu_b       (alu_b),
    .alu_acc     (alu_acc),
    .alu_res     (alu_res)
  );
endmodule

@@ design/scd_checker.sv @@
// Port-level checks for the SCAN disk scheduler, bound to the top level.
module scd_checker #(
  parameter int TRACK_BITS = scd_pkg::DEF_TRACK_BITS
) (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       in_valid,
  input logic                       in_ready,
  input logic                       out_valid,
  input logic                       out_ready,
  input logic                       out_kind,
  input logic [TRACK_BITS-1:0]      out_track,
  input logic [scd_pkg::MOVE_W-1:0] out_move,
  input logic                       out_last
);
  import scd_pkg::*;

  // a stalled result keeps its payload and stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=>
      out_valid && $stable(out_kind) && $stable(out_track) &&
      $stable(out_move) && $stable(out_last))
    else $error("result changed while stalled");

  // only the summary ends a run and carries movement
  a_kind_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_last == out_kind) &&
      ((out_kind == RES_SUMMARY) || (out_move == '0)))
    else $error("result fields disagree with its kind");

  // after the summary nothing is offered until a new request arrives
  a_quiet_after_summary: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && out_last |=> !out_valid)
    else $error("result offered after summary without new request");

  // requests are not taken while the sweep is still emitting completions
  a_no_load_in_sweep: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_kind == RES_DONE) |-> !in_ready)
    else $error("request input ready during sweep");

  // no completion is offered right after a request is taken
  a_no_done_after_req: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !(out_valid && (out_kind == RES_DONE)))
    else $error("completion offered while loading");
endmodule

bind scan_disk_scheduler_unit scd_checker #(.TRACK_BITS(TRACK_BITS)) u_scd_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_ch.valid),
  .in_ready  (in_ch.ready),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_kind  (out_ch.result_kind),
  .out_track (out_ch.track_value),
  .out_move  (out_ch.travel_total),
  .out_last  (out_ch.last_result)
);

@@ tb/scan_disk_scheduler_checker.sv @@
// Scoreboard for the SCAN disk scheduler: tracks registers, predicts each sweep, checks results.
`timescale 1ns / 100ps
module scan_disk_scheduler_checker
  import scd_pkg::*;
#(
  parameter int MAX_REQUESTS = DEF_MAX_REQUESTS
) (
  input  logic clk,
  input  logic rst_n,
  scd_req_if   req_ch,
  scd_res_if   res_ch,
  scd_cfg_if   cfg_ch,
  output int   fault_count,
  output int   results_due,
  output int   results_checked,
  output int   sweeps_closed
);

  typedef struct packed {
    logic                      kind;
    logic [DEF_TRACK_BITS-1:0] track;
    logic [MOVE_W-1:0]         movement;
    logic                      closing;
  } sweep_result_t;

  sweep_result_t completions_due[$];

  logic [CFG_W-1:0] max_track_q;
  logic [CFG_W-1:0] start_head_q;
  logic [CFG_W-1:0] prev_head_q;

  int track_table [MAX_REQUESTS];
  bit served      [MAX_REQUESTS];
  int stored;
  int fault_tally   = 0;
  int checked_tally = 0;
  int closed_tally  = 0;

  function automatic int track_gap(input int a, input int b);
    return (a > b) ? a - b : b - a;
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    if (fault_tally < 40)
      $display("%0t MISMATCH %s: got %0d, expected %0d", $realtime, what, got, want);
    fault_tally++;
  endtask

  // Store one request; on the closing request run the whole elevator sweep.
  task automatic load_and_sweep(input logic [DEF_TRACK_BITS-1:0] trk_in, input logic closing);
    int            top;
    int            trk;
    int            head;
    int            leg;
    int            pending;
    int            guard;
    int            total;
    logic          up;
    sweep_result_t r;
    top = (max_track_q == 0) ? 1 : int'(max_track_q);
    trk = int'(trk_in);
    if (trk > top) trk = top;
    if (stored < MAX_REQUESTS) begin
      track_table[stored] = trk;
      served[stored]      = 1'b0;
      stored++;
    end
    if (!closing) return;

    head = int'(start_head_q);
    if (head > top) head = top;
    up      = int'(prev_head_q) < head;
    leg     = head;
    total   = 0;
    pending = 0;
    // the max may have been lowered since loading: clamp the table again
    for (int i = 0; i < stored; i++) begin
      if (track_table[i] > top) track_table[i] = top;
      if (!served[i]) pending++;
    end

    guard = 4 * (top + 2);
    while (pending > 0 && guard > 0) begin
      guard--;
      if (head == top) begin
        up    = 1'b0;
        total = (total + track_gap(leg, top)) & 'hFFF;
        leg   = top;
      end else if (head == 0) begin
        up    = 1'b1;
        total = (total + leg) & 'hFFF;
        leg   = 0;
      end
      head = up ? head + 1 : head - 1;
      for (int i = 0; i < stored; i++) begin
        if (!served[i] && track_table[i] == head) begin
          served[i]  = 1'b1;
          pending--;
          r.kind     = RES_DONE;
          r.track    = head[DEF_TRACK_BITS-1:0];
          r.movement = '0;
          r.closing  = 1'b0;
          completions_due.push_back(r);
        end
      end
    end
    total      = (total + track_gap(head, leg)) & 'hFFF;
    r.kind     = RES_SUMMARY;
    r.track    = head[DEF_TRACK_BITS-1:0];
    r.movement = total[MOVE_W-1:0];
    r.closing  = 1'b1;
    completions_due.push_back(r);

    stored = 0;
    for (int i = 0; i < MAX_REQUESTS; i++) served[i] = 1'b0;
  endtask

  always @(posedge clk) begin
    sweep_result_t want;
    if (!rst_n) begin
      max_track_q  <= CFG_W'(DEF_MAX_TRACK);
      start_head_q <= '0;
      prev_head_q  <= '0;
      stored = 0;
      for (int i = 0; i < MAX_REQUESTS; i++) served[i] = 1'b0;
      completions_due.delete();
    end else begin
      if (res_ch.valid && res_ch.ready) begin
        if (completions_due.size() == 0) begin
          report_mismatch("result transaction with none due, track",
                          int'(res_ch.track_value), 0);
        end else begin
          want = completions_due.pop_front();
          if (res_ch.result_kind !== want.kind)
            report_mismatch("result_kind", int'(res_ch.result_kind), int'(want.kind));
          if (res_ch.track_value !== want.track)
            report_mismatch("track_value", int'(res_ch.track_value), int'(want.track));
          if (res_ch.travel_total !== want.movement)
            report_mismatch("travel_total", int'(res_ch.travel_total), int'(want.movement));
          if (res_ch.last_result !== want.closing)
            report_mismatch("last_result", int'(res_ch.last_result), int'(want.closing));
          checked_tally++;
          if (want.closing) closed_tally++;
        end
      end
      if (cfg_ch.valid && cfg_ch.ready) begin
        unique case (cfg_ch.index)
          REG_MAX_TRACK:  max_track_q  <= cfg_ch.data;
          REG_START_HEAD: start_head_q <= cfg_ch.data;
          REG_PREV_HEAD:  prev_head_q  <= cfg_ch.data;
          default: ;
        endcase
      end
      if (req_ch.valid && req_ch.ready)
        load_and_sweep(req_ch.request_track, req_ch.last_request);
    end
    fault_count     <= fault_tally;
    results_due     <= completions_due.size();
    results_checked <= checked_tally;
    sweeps_closed   <= closed_tally;
  end

endmodule

@@ tb/scan_disk_scheduler_unit_tb.sv @@
// Top of the SCAN disk scheduler testbench: clock, reset, stimulus, stalls and verdict.
`timescale 1ns / 100ps
module scan_disk_scheduler_unit_tb;
  import scd_pkg::*;

  localparam int QUIET_LIMIT  = 1000000;
  localparam int RANDOM_ITEMS = 420;

  logic clk = 1'b0;
  logic rst_n;

  scd_req_if in_ch ();
  scd_res_if out_ch ();
  scd_cfg_if cfg_ch ();

  int fault_count;
  int results_due;
  int results_checked;
  int sweeps_closed;

  int   send_idle_pct = 9;
  int   take_idle_pct = 72;
  logic burst         = 1'b0;
  int   items_sent    = 0;
  int   quiet_cycles  = 0;

  logic [CFG_W-1:0] geo_start;
  logic [CFG_W-1:0] geo_prev;
  logic [DEF_TRACK_BITS-1:0] batch[$];

  scan_disk_scheduler_unit DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  scan_disk_scheduler_checker checker_i (
    .clk             (clk),
    .rst_n           (rst_n),
    .req_ch          (in_ch),
    .res_ch          (out_ch),
    .cfg_ch          (cfg_ch),
    .fault_count     (fault_count),
    .results_due     (results_due),
    .results_checked (results_checked),
    .sweeps_closed   (sweeps_closed)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (burst) out_ch.ready <= 1'b1;
    else out_ch.ready <= ($urandom_range(99) >= take_idle_pct);
  end

  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("Timeout: no transaction for %0d cycles", QUIET_LIMIT);
      $display("[FAIL] regression broken");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] value);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= value;
    do @(posedge clk); while (!cfg_ch.ready);
  endtask

  task automatic set_geometry(input logic [CFG_W-1:0] top, input logic [CFG_W-1:0] start,
                              input logic [CFG_W-1:0] prev);
    write_reg(REG_MAX_TRACK, top);
    write_reg(REG_START_HEAD, start);
    write_reg(REG_PREV_HEAD, prev);
    cfg_ch.valid <= 1'b0;
    geo_start = start;
    geo_prev  = prev;
  endtask

  // Hold valid high across back-to-back transactions unless an idle gap is drawn; drop it after the closing one.
  task automatic send_request(input logic [DEF_TRACK_BITS-1:0] trk, input logic closing);
    while (!burst && $urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid         <= 1'b1;
    in_ch.request_track <= trk;
    in_ch.last_request  <= closing;
    do @(posedge clk); while (!in_ch.ready);
    items_sent++;
    if (closing) in_ch.valid <= 1'b0;
  endtask

  // Send the queued requests as one sweep, optionally lowering the max part way through.
  task automatic play_batch(input int lower_at, input logic [CFG_W-1:0] lowered_top);
    for (int k = 0; k < batch.size(); k++) begin
      if (k == lower_at) begin
        in_ch.valid <= 1'b0;
        repeat (4) @(posedge clk);
        set_geometry(lowered_top, geo_start, geo_prev);
      end
      send_request(batch[k], k == batch.size() - 1);
    end
    batch.delete();
    do @(posedge clk); while (results_due != 0);
    repeat (4) @(posedge clk);
  endtask

  initial begin
    int               directed_items;
    int               random_sent;
    int               shape;
    int               n_req;
    int               eff;
    int               lower_at;
    int               runs;
    logic [CFG_W-1:0] top;
    logic [CFG_W-1:0] start;
    logic [CFG_W-1:0] prev;
    logic [CFG_W-1:0] lowered_top;

    rst_n               = 1'b0;
    in_ch.valid         = 1'b0;
    in_ch.request_track = '0;
    in_ch.last_request  = 1'b0;
    cfg_ch.valid        = 1'b0;
    cfg_ch.index        = REG_MAX_TRACK;
    cfg_ch.data         = '0;
    out_ch.ready        = 1'b0;
    geo_start           = '0;
    geo_prev            = '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset geometry: head parked at track 0, a request there waits for the return
    batch = '{10'd0, 10'd1023, 10'd150};
    play_batch(-1, '0);
    // max of zero acts as one; start beyond the max is clamped
    set_geometry(10'd0, 10'd5, 10'd0);
    batch = '{10'd0, 10'd1, 10'd1023};
    play_batch(-1, '0);
    // widest disk, head at the top sweeping down
    set_geometry(10'd1023, 10'd1023, 10'd1023);
    batch = '{10'd1023, 10'd0, 10'd512};
    play_batch(-1, '0);
    // max lowered after two requests are stored
    set_geometry(10'd200, 10'd100, 10'd50);
    batch = '{10'd180, 10'd150, 10'd30};
    play_batch(2, 10'd120);
    // single request at the start position
    set_geometry(10'd63, 10'd10, 10'd20);
    batch = '{10'd10};
    play_batch(-1, '0);
    directed_items = items_sent;

    runs        = 0;
    random_sent = 0;
    while (random_sent < RANDOM_ITEMS) begin
      if (random_sent < RANDOM_ITEMS / 3) begin
        send_idle_pct = 9;
        take_idle_pct = 72;
      end else if (random_sent < 2 * RANDOM_ITEMS / 3) begin
        send_idle_pct = 72;
        take_idle_pct = 9;
      end else begin
        send_idle_pct = 0;
        take_idle_pct = 0;
      end
      burst = ($urandom_range(4) == 0);

      shape = (runs == 1) ? 1 : $urandom_range(11);
      if (shape == 0) begin
        top   = 10'($urandom_range(512, 1023));
        n_req = $urandom_range(1, 4);
      end else if (shape == 1) begin
        // overfill the table; the surplus requests are dropped
        top   = 10'($urandom_range(1, 48));
        n_req = $urandom_range(33, 36);
      end else begin
        top   = ($urandom_range(19) == 0) ? 10'd0 : 10'($urandom_range(1, 64));
        n_req = $urandom_range(1, 8);
      end
      eff   = (top == 0) ? 1 : int'(top);
      start = ($urandom_range(3) == 0) ? 10'($urandom_range(1023)) : 10'($urandom_range(eff));
      prev  = ($urandom_range(1) == 0) ? 10'($urandom_range(1023)) : 10'($urandom_range(eff));
      for (int k = 0; k < n_req; k++) begin
        case ($urandom_range(7))
          0:       batch.push_back(10'($urandom_range(1023)));
          1:       batch.push_back(start);
          default: batch.push_back(10'($urandom_range(eff)));
        endcase
      end
      lower_at    = (n_req >= 3 && $urandom_range(7) == 0) ? $urandom_range(1, n_req - 1) : -1;
      lowered_top = 10'($urandom_range(1, eff));

      set_geometry(top, start, prev);
      play_batch(lower_at, lowered_top);
      runs++;
      random_sent = items_sent - directed_items;
    end

    burst = 1'b0;
    do @(posedge clk); while (results_due != 0);
    repeat (16) @(posedge clk);

    $display("Ran %0d sweeps from %0d requests; %0d result transactions checked.",
             sweeps_closed, items_sent, results_checked);
    $display("Geometries spanned max track 0 to 1023, with overfilled tables and mid-load max cuts.");
    if (fault_count == 0 && results_due == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
